>>> rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants for the windowed sample statistics core.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int DEPTH   = 64;                  // window entries
    localparam int AW      = $clog2(DEPTH);       // ring address width
    localparam int CW      = $clog2(DEPTH + 1);   // counter that can hold DEPTH
    localparam int SAMP_W  = 32;
    localparam int PER_W   = 16;
    localparam int AVG_W   = 48;
    localparam int SUM_W   = SAMP_W + AW;
    localparam int DVD_W   = 48;                  // divider dividend width
    localparam int DVS_W   = 32;                  // divider divisor width

    localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(100);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_MODW,
        S_LOAD,
        S_SORT,
        S_SCAN,
        S_AVG,
        S_AVGW,
        S_EMIT
    } wss_state_t;

    typedef struct packed {
        logic step;        // take the accepted sample
        logic mod_start;   // start count modulo period
        logic clr_cnt;     // clear the sweep counter
        logic load_en;     // ring -> sort cells
        logic sort_en;     // one odd-even pass
        logic scan_en;     // shift out, sum and pick
        logic avg_start;   // apply median/min/max, start average divide
        logic avg_apply;   // commit new average
        logic emit;        // load output register
    } wss_cmd_t;

    typedef struct packed {
        logic period_zero;
        logic div_done;
        logic rem_zero;
        logic cnt_last;    // counter at DEPTH-1
        logic cnt_full;    // counter at DEPTH
        logic out_free;
    } wss_stat_t;

endpackage

>>> rtl/wss_if.sv
// ----------------------------------------------------------------------------
// wss interfaces
// Valid/ready channels for samples, results and the period register.
// ----------------------------------------------------------------------------
interface wss_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_us;
    modport source (output valid, output sample_us, input ready);
    modport sink   (input valid, input sample_us, output ready);
endinterface

interface wss_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] latest_us;
    logic [31:0] minimum_us;
    logic [31:0] maximum_us;
    logic [31:0] median_us;
    logic [47:0] average_value;
    logic        updated;
    modport source (output valid, output latest_us, output minimum_us, output maximum_us,
                    output median_us, output average_value, output updated, input ready);
    modport sink   (input valid, input latest_us, input minimum_us, input maximum_us,
                    input median_us, input average_value, input updated, output ready);
endinterface

interface wss_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/windowed_sample_statistics_core.sv
// ----------------------------------------------------------------------------
// windowed_sample_statistics_core
// Sliding-window median, running min/max and running average over duration samples.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | moves
//  ---------+-----+------------------------------------------+-------------------
//  sample   | in  | sample_us[31:0]                          | one word per item
//  result   | out | latest/minimum/maximum/median, average,  | one word per item
//           |     | updated                                  |
//  cfg      | in  | data[15:0] = window_period               | always ready
//
//  A word without recalculation goes from accept to result valid through
//  step, start, the modulo of the count by the period on the shared 48-bit
//  serial divider, and emit.
//  A recalculation adds the load, sort and scan sweeps, an apply step and
//  a second divide on the same divider.
//  rst_n clears control and statistics; the ring needs no clearing pass.
//  A finished word waits in the output register; the next sample is taken
//  while it waits, and its own result stalls only at emit.
// ----------------------------------------------------------------------------
module windowed_sample_statistics_core
(
    input  logic      clk,
    input  logic      rst_n,
    wss_in_if.sink    sample,
    wss_out_if.source result,
    wss_cfg_if.sink   cfg
);
    import wss_pkg::*;

    wss_cmd_t  cmd;
    wss_stat_t stat;

    assign cfg.ready = 1'b1;

    // sequencer
    wss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // ring, sort cells, divider, output word
    wss_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample_us     (sample.sample_us),
        .cfg_valid     (cfg.valid),
        .cfg_data      (cfg.data),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .latest_us     (result.latest_us),
        .minimum_us    (result.minimum_us),
        .maximum_us    (result.maximum_us),
        .median_us     (result.median_us),
        .average_value (result.average_value),
        .updated       (result.updated)
    );

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample accepted while busy");

    // widening never crosses the extremes
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.minimum_us <= result.maximum_us)
        else $error("minimum above maximum");

    // an emit always happens with room in the output register
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result overwritten");

endmodule

>>> rtl/wss_div.sv
// ----------------------------------------------------------------------------
// wss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wss_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wss_pkg::DVD_W-1:0] dividend,
    input  logic [wss_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [wss_pkg::DVD_W-1:0] quotient,
    output logic [wss_pkg::DVS_W-1:0] remainder
);
    import wss_pkg::*;

    localparam int BW = $clog2(DVD_W);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg, dvs_reg;
    logic [BW-1:0]    bit_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   trial;
    logic             qbit;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else if (busy_reg)
        begin
            bit_reg <= bit_reg + 1'b1;
            if (bit_reg == BW'(DVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], qbit};
            rem_reg <= qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/wss_ctrl.sv
// ----------------------------------------------------------------------------
// wss_ctrl
// Sequencer: step, period test, load, sort, scan, average divide, emit.
// ----------------------------------------------------------------------------
module wss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wss_pkg::wss_stat_t stat,
    output wss_pkg::wss_cmd_t  cmd
);
    import wss_pkg::*;

    wss_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_MOD;
            S_MOD:   state_next = stat.period_zero ? S_EMIT : S_MODW;
            S_MODW:  if (stat.div_done) state_next = stat.rem_zero ? S_LOAD : S_EMIT;
            S_LOAD:  if (stat.cnt_full) state_next = S_SORT;
            S_SORT:  if (stat.cnt_last) state_next = S_SCAN;
            S_SCAN:  if (stat.cnt_last) state_next = S_AVG;
            S_AVG:   state_next = S_AVGW;
            S_AVGW:  if (stat.div_done) state_next = S_EMIT;
            S_EMIT:  if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.step = in_valid;
            end
            S_MOD:   cmd.mod_start = !stat.period_zero;
            S_MODW:  cmd.clr_cnt = stat.div_done;
            S_LOAD:
            begin
                cmd.load_en = 1'b1;
                cmd.clr_cnt = stat.cnt_full;
            end
            S_SORT:
            begin
                cmd.sort_en = 1'b1;
                cmd.clr_cnt = stat.cnt_last;
            end
            S_SCAN:  cmd.scan_en = 1'b1;
            S_AVG:   cmd.avg_start = 1'b1;
            S_AVGW:  cmd.avg_apply = stat.div_done;
            S_EMIT:  cmd.emit = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

>>> rtl/wss_dpath.sv
// ----------------------------------------------------------------------------
// wss_dpath
// Sample ring, sort cells, statistics registers, divider and output word.
// ----------------------------------------------------------------------------
module wss_dpath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  wss_pkg::wss_cmd_t         cmd,
    output wss_pkg::wss_stat_t        stat,
    input  logic [wss_pkg::SAMP_W-1:0] sample_us,
    input  logic                      cfg_valid,
    input  logic [wss_pkg::PER_W-1:0] cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [wss_pkg::SAMP_W-1:0] latest_us,
    output logic [wss_pkg::SAMP_W-1:0] minimum_us,
    output logic [wss_pkg::SAMP_W-1:0] maximum_us,
    output logic [wss_pkg::SAMP_W-1:0] median_us,
    output logic [wss_pkg::AVG_W-1:0]  average_value,
    output logic                      updated
);
    import wss_pkg::*;

    // statistics state
    logic [PER_W-1:0]  period_reg;
    logic [AW-1:0]     wp_reg;
    logic [CW-1:0]     fill_reg;
    logic [31:0]       count_reg;
    logic              seeded_reg;
    logic [SAMP_W-1:0] last_reg, min_reg, max_reg, median_reg;
    logic [AVG_W-1:0]  avg_reg;
    logic              upd_reg;

    // sweep state
    logic [SAMP_W-1:0] ring_mem [DEPTH];
    logic [SAMP_W-1:0] rd_reg;
    logic              ld_vld_reg;
    logic [CW-1:0]     ld_idx_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SAMP_W-1:0] cell_reg  [DEPTH];
    logic [SAMP_W-1:0] cell_sort [DEPTH];
    logic [SUM_W-1:0]  sum_reg;
    logic [SAMP_W-1:0] lo_reg, hi_reg, ma_reg, mb_reg;
    logic              ge_reg;

    // output word
    logic              ov_reg;
    logic [SAMP_W-1:0] o_last_reg, o_min_reg, o_max_reg, o_med_reg;
    logic [AVG_W-1:0]  o_avg_reg;
    logic              o_upd_reg;

    // divider
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic [DVS_W-1:0]  div_r;

    logic [CW-1:0]     mid_hi, mid_lo;
    logic [SAMP_W:0]   mid_sum;
    logic [AVG_W:0]    avg_up;

    assign mid_hi  = fill_reg >> 1;
    assign mid_lo  = CW'(mid_hi - 1'b1);
    assign mid_sum = {1'b0, ma_reg} + {1'b0, mb_reg};
    assign avg_up  = {1'b0, avg_reg} + {1'b0, div_q};

    assign div_start = cmd.mod_start || cmd.avg_start;
    always_comb
    begin
        if (cmd.avg_start)
        begin
            div_dvd = (AVG_W'(sum_reg) >= avg_reg) ? AVG_W'(sum_reg) - avg_reg
                                                   : avg_reg - AVG_W'(sum_reg);
            div_dvs = count_reg;
        end
        else
        begin
            div_dvd = DVD_W'(count_reg);
            div_dvs = DVS_W'(period_reg);
        end
    end

    wss_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // odd-even transposition pass, parity from the pass counter
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            cell_sort[i] = cell_reg[i];
        for (int i = 0; i + 1 < DEPTH; i++)
        begin
            if ((i % 2) == int'(cnt_reg[0]) && cell_reg[i] > cell_reg[i+1])
            begin
                cell_sort[i]   = cell_reg[i+1];
                cell_sort[i+1] = cell_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            wp_reg     <= '0;
            fill_reg   <= '0;
            count_reg  <= '0;
            seeded_reg <= 1'b0;
            last_reg   <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            median_reg <= '0;
            avg_reg    <= '0;
            upd_reg    <= 1'b0;
            cnt_reg    <= '0;
            ld_vld_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                period_reg <= cfg_data;
            if (cmd.step)
            begin
                last_reg <= sample_us;
                upd_reg  <= 1'b0;
                if (count_reg != '1)
                    count_reg <= count_reg + 1'b1;
                if (fill_reg != CW'(DEPTH))
                    fill_reg <= fill_reg + 1'b1;
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (!seeded_reg)
                begin
                    min_reg    <= sample_us;
                    max_reg    <= sample_us;
                    seeded_reg <= 1'b1;
                end
            end
            if (cmd.clr_cnt)
                cnt_reg <= '0;
            else if (cmd.load_en || cmd.sort_en || cmd.scan_en)
                cnt_reg <= cnt_reg + 1'b1;
            ld_vld_reg <= cmd.load_en && (cnt_reg < CW'(DEPTH));
            if (cmd.avg_start)
            begin
                median_reg <= fill_reg[0] ? mb_reg : mid_sum[SAMP_W:1];
                if (lo_reg < min_reg)
                    min_reg <= lo_reg;
                if (hi_reg > max_reg)
                    max_reg <= hi_reg;
            end
            if (cmd.avg_apply)
            begin
                upd_reg <= 1'b1;
                if (ge_reg)
                    avg_reg <= avg_up[AVG_W] ? '1 : avg_up[AVG_W-1:0];
                else
                    avg_reg <= avg_reg - div_q;
            end
            if (cmd.emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
            ring_mem[wp_reg] <= sample_us;
        rd_reg     <= ring_mem[cnt_reg[AW-1:0]];
        ld_idx_reg <= cnt_reg;

        // load shifts in at the top; unfilled slots sort to the end
        if (ld_vld_reg)
        begin
            for (int i = 0; i + 1 < DEPTH; i++)
                cell_reg[i] <= cell_reg[i+1];
            cell_reg[DEPTH-1] <= (ld_idx_reg < fill_reg) ? rd_reg : '1;
        end
        else if (cmd.sort_en)
        begin
            for (int i = 0; i < DEPTH; i++)
                cell_reg[i] <= cell_sort[i];
        end
        else if (cmd.scan_en)
        begin
            for (int i = 0; i + 1 < DEPTH; i++)
                cell_reg[i] <= cell_reg[i+1];
        end

        if (cmd.clr_cnt)
            sum_reg <= '0;
        else if (cmd.scan_en && cnt_reg < fill_reg)
            sum_reg <= sum_reg + SUM_W'(cell_reg[0]);
        if (cmd.scan_en)
        begin
            if (cnt_reg == '0)
                lo_reg <= cell_reg[0];
            if (cnt_reg == CW'(fill_reg - 1'b1))
                hi_reg <= cell_reg[0];
            if (cnt_reg == mid_lo)
                ma_reg <= cell_reg[0];
            if (cnt_reg == mid_hi)
                mb_reg <= cell_reg[0];
        end
        if (cmd.avg_start)
            ge_reg <= (AVG_W'(sum_reg) >= avg_reg);

        if (cmd.emit)
        begin
            o_last_reg <= last_reg;
            o_min_reg  <= min_reg;
            o_max_reg  <= max_reg;
            o_med_reg  <= median_reg;
            o_avg_reg  <= avg_reg;
            o_upd_reg  <= upd_reg;
        end
    end

    assign stat.period_zero = (period_reg == '0);
    assign stat.div_done    = div_done;
    assign stat.rem_zero    = (div_r == '0);
    assign stat.cnt_last    = (cnt_reg == CW'(DEPTH - 1));
    assign stat.cnt_full    = (cnt_reg == CW'(DEPTH));
    assign stat.out_free    = !ov_reg || out_ready;

    assign out_valid     = ov_reg;
    assign latest_us     = o_last_reg;
    assign minimum_us    = o_min_reg;
    assign maximum_us    = o_max_reg;
    assign median_us     = o_med_reg;
    assign average_value = o_avg_reg;
    assign updated       = o_upd_reg;

endmodule
